FILE: rtl/mtp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the monomial text parser.
// Used by the front, queue, back and top-level modules; depends on nothing.
package mtp_pkg;

  localparam logic [7:0] CH_A     = 8'h61;  // 'a'
  localparam logic [7:0] CH_Z     = 8'h7A;  // 'z'
  localparam logic [7:0] CH_0     = 8'h30;  // '0'
  localparam logic [7:0] CH_9     = 8'h39;  // '9'
  localparam logic [7:0] CH_CARET = 8'h5E;  // '^'
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'

  localparam int SYM_W   = 8;
  localparam int VIDX_W  = 5;
  localparam int EXP_W   = 16;
  localparam int COEF_W  = 32;
  localparam int MAG_W   = 31;
  localparam int STAT_W  = 2;

  localparam logic [MAG_W-1:0] COEF_MAX = 31'h7FFF_FFFF;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = 3;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_UNKNOWN = 2'd1;
  localparam logic [STAT_W-1:0] STAT_STOPPED = 2'd2;

  typedef enum logic [2:0] {
    ST_BEGIN,
    ST_SIGN,
    ST_COEF,
    ST_VAR,
    ST_CARET,
    ST_POWER,
    ST_HALT,
    ST_EMIT
  } parse_state_t;

  typedef enum logic [2:0] {
    CL_LETTER,
    CL_DIGIT,
    CL_CARET,
    CL_SIGN,
    CL_OTHER,
    CL_END
  } sym_class_t;

  // One classified word as it travels from the front to the back.
  typedef struct packed {
    sym_class_t        cls;
    logic [VIDX_W-1:0] val;    // letter index or digit value
    logic              minus;  // sign word was '-'
  } q_item_t;

endpackage

FILE: rtl/monomial_text_parser.sv
`timescale 1ns / 1ps
// Monomial text parser, top level.
// Feed one character of a term such as -12ab^3c per input word on in_symbol,
// then a word with in_end_marker high. The end marker produces NUM_VARIABLES
// result words, one per variable in index order, the last with out_last set.
// Each result carries the variable's exponent, the signed coefficient and a
// status: 0 ok, 1 unknown symbol, 2 parse stopped early.
// Throughput: one character per cycle while in_stall is low, set by the parser
// in the back end, which consumes one queued word per cycle outside emission.
// Emission gives one result per cycle while out_stall is low.
// The end marker goes through a queue slot and the parser's emit state before
// the first result is loaded; words still queued ahead of it delay it further.
// A four-word queue sits between the classifier and the parser, so
// characters keep being accepted during emission until the queue fills;
// in_stall is high exactly while the queue is full.
// When out_stall is high with a result valid, the result register holds its
// word and emission pauses. Reset (rst_n low, synchronous) empties the queue,
// clears every exponent and returns the parser to ST_BEGIN with coefficient 1.
// Depends on mtp_pkg, mtp_front, mtp_queue and mtp_back.
module monomial_text_parser #(
  parameter int NUM_VARIABLES = 26
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [mtp_pkg::SYM_W-1:0]   in_symbol,
  input  logic                        in_end_marker,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mtp_pkg::VIDX_W-1:0]  out_variable_index,
  output logic [mtp_pkg::EXP_W-1:0]   out_exponent,
  output logic signed [mtp_pkg::COEF_W-1:0] out_coefficient,
  output logic [mtp_pkg::STAT_W-1:0]  out_status,
  output logic                        out_last
);
  import mtp_pkg::*;

  logic    q_full;
  logic    q_push;
  logic    q_pop;
  logic    q_valid;
  q_item_t q_wdata;
  q_item_t q_rdata;

  mtp_front #(
    .NUM_VARIABLES(NUM_VARIABLES)
  ) u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_symbol    (in_symbol),
    .in_end_marker(in_end_marker),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  mtp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rvalid(q_valid),
    .rdata (q_rdata)
  );

  mtp_back #(
    .NUM_VARIABLES(NUM_VARIABLES)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_rdata           (q_rdata),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_variable_index(out_variable_index),
    .out_exponent      (out_exponent),
    .out_coefficient   (out_coefficient),
    .out_status        (out_status),
    .out_last          (out_last)
  );

endmodule

FILE: rtl/mtp_front.sv
`timescale 1ns / 1ps
// Front end: accepts input words and classifies each character.
// Depends on mtp_pkg; feeds mtp_queue.
module mtp_front #(
  parameter int NUM_VARIABLES = 26
) (
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [mtp_pkg::SYM_W-1:0]  in_symbol,
  input  logic                       in_end_marker,
  input  logic                       q_full,
  output logic                       q_push,
  output mtp_pkg::q_item_t           q_wdata
);
  import mtp_pkg::*;

  logic [SYM_W-1:0] letter_off;
  logic [SYM_W-1:0] digit_off;

  assign letter_off = in_symbol - CH_A;
  assign digit_off  = in_symbol - CH_0;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_wdata.cls   = CL_OTHER;
    q_wdata.val   = '0;
    q_wdata.minus = (in_symbol == CH_MINUS);
    if (in_end_marker) begin
      q_wdata.cls = CL_END;
    end else if (in_symbol >= CH_A && in_symbol <= CH_Z) begin
      // Letters past the configured variable count are unknown symbols.
      if (letter_off < SYM_W'(NUM_VARIABLES)) begin
        q_wdata.cls = CL_LETTER;
        q_wdata.val = letter_off[VIDX_W-1:0];
      end
    end else if (in_symbol >= CH_0 && in_symbol <= CH_9) begin
      q_wdata.cls = CL_DIGIT;
      q_wdata.val = digit_off[VIDX_W-1:0];
    end else if (in_symbol == CH_CARET) begin
      q_wdata.cls = CL_CARET;
    end else if (in_symbol == CH_MINUS || in_symbol == CH_PLUS) begin
      q_wdata.cls = CL_SIGN;
    end
  end

endmodule

FILE: rtl/mtp_queue.sv
`timescale 1ns / 1ps
// Short queue of classified words between the front and the back.
// Depends on mtp_pkg.
module mtp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mtp_pkg::q_item_t  wdata,
  output logic              full,
  input  logic              pop,
  output logic              rvalid,
  output mtp_pkg::q_item_t  rdata
);
  import mtp_pkg::*;

  q_item_t             slot_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;

  assign full   = (count_r == QCNT_W'(QDEPTH));
  assign rvalid = (count_r != '0);
  assign rdata  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: rtl/mtp_back.sv
`timescale 1ns / 1ps
// Back end: the term parser, the exponent store and the result register.
// Depends on mtp_pkg; takes classified words from mtp_queue.
module mtp_back #(
  parameter int NUM_VARIABLES = 26
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  mtp_pkg::q_item_t            q_rdata,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mtp_pkg::VIDX_W-1:0]  out_variable_index,
  output logic [mtp_pkg::EXP_W-1:0]   out_exponent,
  output logic signed [mtp_pkg::COEF_W-1:0] out_coefficient,
  output logic [mtp_pkg::STAT_W-1:0]  out_status,
  output logic                        out_last
);
  import mtp_pkg::*;

  localparam int IDX_W = (NUM_VARIABLES > 1) ? $clog2(NUM_VARIABLES) : 1;

  parse_state_t        state_r, state_nxt;
  logic                neg_r, neg_nxt;
  logic                pend_neg_r, pend_neg_nxt;
  logic [MAG_W-1:0]    coef_r, coef_nxt;
  logic [MAG_W-1:0]    digits_r, digits_nxt;
  logic [VIDX_W-1:0]   cur_var_r, cur_var_nxt;
  logic [EXP_W-1:0]    power_r, power_nxt;
  logic [STAT_W-1:0]   err_r, err_nxt;
  logic [IDX_W-1:0]    cnt_r, cnt_nxt;
  logic [EXP_W-1:0]    store_r [NUM_VARIABLES];

  logic                emitting;
  logic                load;
  logic                last_idx;
  logic [IDX_W-1:0]    st_addr;
  logic [EXP_W-1:0]    st_rdata;
  logic                st_we;
  logic [EXP_W-1:0]    st_wdata;
  logic [MAG_W+3:0]    digits_x10;
  logic [EXP_W-1:0]    power_x10;
  logic [COEF_W-1:0]   coef_mag;

  logic                out_valid_r, out_valid_nxt;
  logic [VIDX_W-1:0]   idx_out_r;
  logic [EXP_W-1:0]    exp_out_r;
  logic [COEF_W-1:0]   coef_out_r;
  logic [STAT_W-1:0]   stat_out_r;
  logic                last_out_r;

  assign emitting = (state_r == ST_EMIT);
  assign q_pop    = q_valid && !emitting;
  assign load     = emitting && (!out_valid_r || !out_stall);
  assign last_idx = (cnt_r == IDX_W'(NUM_VARIABLES - 1));

  // Parsing and emission never overlap, so the store needs one address.
  assign st_addr  = emitting ? cnt_r : cur_var_r[IDX_W-1:0];
  assign st_rdata = store_r[st_addr];

  assign digits_x10 = {1'b0, digits_r, 3'b000} + {3'b000, digits_r, 1'b0}
                      + {{(MAG_W-1){1'b0}}, q_rdata.val};
  assign power_x10  = (power_r << 3) + (power_r << 1)
                      + {{(EXP_W-VIDX_W){1'b0}}, q_rdata.val};
  assign coef_mag   = {1'b0, coef_r};

  // Next parse state.
  always_comb begin
    state_nxt = state_r;
    if (emitting) begin
      if (load && last_idx) begin
        state_nxt = ST_BEGIN;
      end
    end else if (q_pop) begin
      if (q_rdata.cls == CL_END) begin
        state_nxt = ST_EMIT;
      end else if (state_r != ST_HALT) begin
        state_nxt = ST_HALT;
        unique case (state_r)
          ST_BEGIN: begin
            if (q_rdata.cls == CL_DIGIT) state_nxt = ST_COEF;
            else if (q_rdata.cls == CL_LETTER) state_nxt = ST_VAR;
            else if (q_rdata.cls == CL_SIGN) state_nxt = ST_SIGN;
          end
          ST_SIGN, ST_COEF: begin
            if (q_rdata.cls == CL_DIGIT) state_nxt = ST_COEF;
            else if (q_rdata.cls == CL_LETTER) state_nxt = ST_VAR;
          end
          ST_VAR: begin
            if (q_rdata.cls == CL_CARET) state_nxt = ST_CARET;
            else if (q_rdata.cls == CL_LETTER) state_nxt = ST_VAR;
          end
          ST_CARET: begin
            if (q_rdata.cls == CL_DIGIT) state_nxt = ST_POWER;
          end
          ST_POWER: begin
            if (q_rdata.cls == CL_DIGIT) state_nxt = ST_POWER;
            else if (q_rdata.cls == CL_LETTER) state_nxt = ST_VAR;
          end
          default: state_nxt = ST_HALT;
        endcase
      end
    end
  end

  // Datapath updates that go with each transition.
  always_comb begin
    neg_nxt      = neg_r;
    pend_neg_nxt = pend_neg_r;
    coef_nxt     = coef_r;
    digits_nxt   = digits_r;
    cur_var_nxt  = cur_var_r;
    power_nxt    = power_r;
    err_nxt      = err_r;
    cnt_nxt      = cnt_r;
    st_we        = 1'b0;
    st_wdata     = '0;
    if (emitting) begin
      if (load) begin
        // Each entry is cleared as it goes out, ready for the next term.
        st_we   = 1'b1;
        cnt_nxt = last_idx ? '0 : cnt_r + 1'b1;
        if (last_idx) begin
          neg_nxt      = 1'b0;
          pend_neg_nxt = 1'b0;
          coef_nxt     = MAG_W'(1);
          digits_nxt   = '0;
          cur_var_nxt  = '0;
          power_nxt    = '0;
          err_nxt      = STAT_OK;
        end
      end
    end else if (q_pop) begin
      if (q_rdata.cls == CL_END) begin
        unique case (state_r)
          ST_COEF: coef_nxt = digits_r;
          ST_VAR: begin
            st_we    = 1'b1;
            st_wdata = st_rdata + 1'b1;
          end
          ST_POWER: begin
            st_we    = 1'b1;
            st_wdata = st_rdata + power_r;
          end
          ST_HALT: ;
          default: if (err_r == STAT_OK) err_nxt = STAT_STOPPED;
        endcase
      end else if (state_r == ST_HALT) begin
        // Characters after a stop are dropped.
      end else if (q_rdata.cls == CL_OTHER) begin
        if (err_r == STAT_OK) err_nxt = STAT_UNKNOWN;
      end else begin
        if (q_rdata.cls == CL_LETTER) begin
          cur_var_nxt = q_rdata.val;
        end
        unique case (state_r)
          ST_BEGIN: begin
            if (q_rdata.cls == CL_DIGIT) begin
              digits_nxt = MAG_W'(q_rdata.val);
            end else if (q_rdata.cls == CL_SIGN) begin
              pend_neg_nxt = q_rdata.minus;
            end else if (q_rdata.cls != CL_LETTER && err_r == STAT_OK) begin
              err_nxt = STAT_STOPPED;
            end
          end
          ST_SIGN: begin
            if (q_rdata.cls == CL_DIGIT || q_rdata.cls == CL_LETTER) begin
              neg_nxt = pend_neg_r;
              if (q_rdata.cls == CL_DIGIT) digits_nxt = MAG_W'(q_rdata.val);
            end else if (err_r == STAT_OK) begin
              err_nxt = STAT_STOPPED;
            end
          end
          ST_COEF: begin
            if (q_rdata.cls == CL_DIGIT) begin
              digits_nxt = (digits_x10 > (MAG_W+4)'(COEF_MAX)) ? COEF_MAX
                                                               : digits_x10[MAG_W-1:0];
            end else if (q_rdata.cls == CL_LETTER) begin
              coef_nxt = digits_r;
            end else if (err_r == STAT_OK) begin
              err_nxt = STAT_STOPPED;
            end
          end
          ST_VAR: begin
            if (q_rdata.cls == CL_LETTER) begin
              st_we    = 1'b1;
              st_wdata = st_rdata + 1'b1;
            end else if (q_rdata.cls != CL_CARET && err_r == STAT_OK) begin
              err_nxt = STAT_STOPPED;
            end
          end
          ST_CARET: begin
            if (q_rdata.cls == CL_DIGIT) begin
              power_nxt = EXP_W'(q_rdata.val);
            end else if (err_r == STAT_OK) begin
              err_nxt = STAT_STOPPED;
            end
          end
          ST_POWER: begin
            if (q_rdata.cls == CL_DIGIT) begin
              power_nxt = power_x10;
            end else if (q_rdata.cls == CL_LETTER) begin
              st_we    = 1'b1;
              st_wdata = st_rdata + power_r;
            end else if (err_r == STAT_OK) begin
              err_nxt = STAT_STOPPED;
            end
          end
          default: if (err_r == STAT_OK) err_nxt = STAT_STOPPED;
        endcase
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_BEGIN;
      neg_r       <= 1'b0;
      pend_neg_r  <= 1'b0;
      coef_r      <= MAG_W'(1);
      digits_r    <= '0;
      cur_var_r   <= '0;
      power_r     <= '0;
      err_r       <= STAT_OK;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      neg_r       <= neg_nxt;
      pend_neg_r  <= pend_neg_nxt;
      coef_r      <= coef_nxt;
      digits_r    <= digits_nxt;
      cur_var_r   <= cur_var_nxt;
      power_r     <= power_nxt;
      err_r       <= err_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_VARIABLES; i++) begin
        store_r[i] <= '0;
      end
    end else if (st_we) begin
      store_r[st_addr] <= st_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      idx_out_r  <= VIDX_W'(cnt_r);
      exp_out_r  <= (coef_r == '0) ? '0 : st_rdata;
      coef_out_r <= neg_r ? ('0 - coef_mag) : coef_mag;
      stat_out_r <= err_r;
      last_out_r <= last_idx;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_variable_index = idx_out_r;
  assign out_exponent       = exp_out_r;
  assign out_coefficient    = coef_out_r;
  assign out_status         = stat_out_r;
  assign out_last           = last_out_r;

endmodule

FILE: rtl/mtp_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the result channel of the monomial text parser.
// Depends only on the top-level ports; bound to monomial_text_parser below.
module mtp_checker #(
  parameter int NUM_VARIABLES = 26
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [4:0]  out_variable_index,
  input logic [15:0] out_exponent,
  input logic [31:0] out_coefficient,
  input logic [1:0]  out_status,
  input logic        out_last
);

  // A stalled result word holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_variable_index)
      && $stable(out_exponent) && $stable(out_coefficient) && $stable(out_last))
    else $error("stalled result word changed");

  // The last flag marks exactly the highest variable index.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_variable_index == 5'(NUM_VARIABLES - 1))))
    else $error("last flag does not match variable index");

  // Within a run the next word follows at once with the next index.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid
      && out_variable_index == $past(out_variable_index) + 5'd1
      && out_coefficient == $past(out_coefficient)
      && out_status == $past(out_status))
    else $error("result run broken");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("undefined status code");

endmodule

bind monomial_text_parser mtp_checker #(
  .NUM_VARIABLES(NUM_VARIABLES)
) u_mtp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_variable_index(out_variable_index),
  .out_exponent      (out_exponent),
  .out_coefficient   (out_coefficient),
  .out_status        (out_status),
  .out_last          (out_last)
);

FILE: tb/tb_monomial_text_parser.sv
`timescale 1ns / 1ps
// Self-checking testbench for monomial_text_parser: drives character words and end markers,
// predicts the 26 result words of every term and checks them in order.
// Depends on mtp_pkg and the monomial_text_parser RTL.
module tb_monomial_text_parser;
  import mtp_pkg::*;

  localparam int NV = 26;
  localparam int RANDOM_WORDS = 350;

  typedef logic signed [COEF_W:0] field_t;

  typedef struct {
    logic [VIDX_W-1:0]        var_index;
    logic [EXP_W-1:0]         exponent;
    logic signed [COEF_W-1:0] coefficient;
    logic [STAT_W-1:0]        status;
    logic                     last;
  } term_result_t;

  // Tracks the parser state of the current term and holds the result words still owed.
  class monomial_checker;
    parse_state_t       state;
    bit                 neg;
    bit                 pend_neg;
    logic [31:0]        coef_applied;
    logic [31:0]        coef_digits;
    logic [VIDX_W-1:0]  cur_var;
    logic [EXP_W-1:0]   power_acc;
    logic [EXP_W-1:0]   exps [NV];
    logic [STAT_W-1:0]  err;
    term_result_t       exp_results [$];
    int                 errors;
    int                 words_in;
    int                 results_seen;
    int                 terms;
    int                 term_status [3];

    function new();
      errors = 0;
      words_in = 0;
      results_seen = 0;
      terms = 0;
      term_status = '{0, 0, 0};
      clear_term();
    endfunction

    function void clear_term();
      state = ST_BEGIN;
      neg = 0;
      pend_neg = 0;
      coef_applied = 32'd1;
      coef_digits = '0;
      cur_var = '0;
      power_acc = '0;
      foreach (exps[i]) exps[i] = '0;
      err = STAT_OK;
    endfunction

    function void halt(logic [STAT_W-1:0] code);
      if (err == STAT_OK) err = code;
      state = ST_HALT;
    endfunction

    function void start_var(logic [7:0] v);
      cur_var = v[VIDX_W-1:0];
      state = ST_VAR;
    endfunction

    function void take_char(logic [7:0] c);
      sym_class_t  cls;
      logic [7:0]  v;
      logic [63:0] wide;
      v = '0;
      if (state == ST_HALT) return;
      if (c >= CH_A && c <= CH_Z) begin
        v = c - CH_A;
        cls = (v < NV) ? CL_LETTER : CL_OTHER;
      end else if (c >= CH_0 && c <= CH_9) begin
        v = c - CH_0;
        cls = CL_DIGIT;
      end else if (c == CH_CARET) begin
        cls = CL_CARET;
      end else if (c == CH_MINUS || c == CH_PLUS) begin
        cls = CL_SIGN;
      end else begin
        cls = CL_OTHER;
      end
      if (cls == CL_OTHER) begin
        halt(STAT_UNKNOWN);
        return;
      end
      case (state)
        ST_BEGIN: begin
          if (cls == CL_DIGIT) begin
            coef_digits = 32'(v);
            state = ST_COEF;
          end else if (cls == CL_LETTER) begin
            start_var(v);
          end else if (cls == CL_SIGN) begin
            pend_neg = (c == CH_MINUS);
            state = ST_SIGN;
          end else begin
            halt(STAT_STOPPED);
          end
        end
        ST_SIGN: begin
          // The sign only counts once a digit or a letter follows it.
          if (cls == CL_DIGIT) begin
            neg = pend_neg;
            coef_digits = 32'(v);
            state = ST_COEF;
          end else if (cls == CL_LETTER) begin
            neg = pend_neg;
            start_var(v);
          end else begin
            halt(STAT_STOPPED);
          end
        end
        ST_COEF: begin
          if (cls == CL_DIGIT) begin
            wide = 64'(coef_digits);
            wide = wide * 64'd10 + 64'(v);
            coef_digits = (wide > COEF_MAX) ? {1'b0, COEF_MAX} : wide[31:0];
          end else if (cls == CL_LETTER) begin
            coef_applied = coef_digits;
            start_var(v);
          end else begin
            halt(STAT_STOPPED);
          end
        end
        ST_VAR: begin
          if (cls == CL_CARET) begin
            state = ST_CARET;
          end else if (cls == CL_LETTER) begin
            exps[cur_var] = exps[cur_var] + 1'b1;
            start_var(v);
          end else begin
            halt(STAT_STOPPED);
          end
        end
        ST_CARET: begin
          if (cls == CL_DIGIT) begin
            power_acc = EXP_W'(v);
            state = ST_POWER;
          end else begin
            halt(STAT_STOPPED);
          end
        end
        ST_POWER: begin
          if (cls == CL_DIGIT) begin
            power_acc = power_acc * 16'd10 + EXP_W'(v);
          end else if (cls == CL_LETTER) begin
            exps[cur_var] = exps[cur_var] + power_acc;
            start_var(v);
          end else begin
            halt(STAT_STOPPED);
          end
        end
        default: halt(STAT_STOPPED);
      endcase
    endfunction

    function void take_end();
      term_result_t r;
      logic [31:0]  coef;
      case (state)
        ST_COEF:  coef_applied = coef_digits;
        ST_VAR:   exps[cur_var] = exps[cur_var] + 1'b1;
        ST_POWER: exps[cur_var] = exps[cur_var] + power_acc;
        ST_HALT:  ;
        default:  halt(STAT_STOPPED);
      endcase
      coef = neg ? (32'd0 - coef_applied) : coef_applied;
      for (int i = 0; i < NV; i++) begin
        r.var_index = VIDX_W'(i);
        r.exponent = (coef_applied == 0) ? '0 : exps[i];
        r.coefficient = coef;
        r.status = err;
        r.last = (i == NV - 1);
        exp_results.push_back(r);
      end
      terms++;
      term_status[err]++;
      clear_term();
    endfunction

    function void note_word(logic [7:0] sym, logic end_marker);
      words_in++;
      if (end_marker) take_end();
      else take_char(sym);
    endfunction

    function void check_field(string name, field_t want, field_t got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch in result %0d: expected %0d, got %0d",
                 $time, name, results_seen, want, got);
      end
    endfunction

    function void check_result(term_result_t got);
      term_result_t want;
      if (exp_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word: variable %0d exponent %0d coefficient %0d",
                 $time, got.var_index, got.exponent, got.coefficient);
        return;
      end
      want = exp_results.pop_front();
      check_field("variable_index", want.var_index, got.var_index);
      check_field("exponent", want.exponent, got.exponent);
      check_field("coefficient", want.coefficient, got.coefficient);
      check_field("status", want.status, got.status);
      check_field("last", want.last, got.last);
      results_seen++;
    endfunction

    function int pending();
      return exp_results.size();
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [SYM_W-1:0]          in_symbol = '0;
  logic                      in_end_marker = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [VIDX_W-1:0]         out_variable_index;
  logic [EXP_W-1:0]          out_exponent;
  logic signed [COEF_W-1:0]  out_coefficient;
  logic [STAT_W-1:0]         out_status;
  logic                      out_last;

  logic                      calm = 1'b0;
  logic [7:0]                term_text [$];
  monomial_checker           sb;
  int                        words_sent = 0;

  monomial_text_parser #(.NUM_VARIABLES(NV)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_symbol          (in_symbol),
    .in_end_marker      (in_end_marker),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_variable_index (out_variable_index),
    .out_exponent       (out_exponent),
    .out_coefficient    (out_coefficient),
    .out_status         (out_status),
    .out_last           (out_last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 28);
  end

  // Both channels are sampled at the edge, before any register in the block updates.
  always @(posedge clk) begin
    term_result_t r;
    if (rst_n && in_valid && !in_stall) sb.note_word(in_symbol, in_end_marker);
    if (rst_n && out_valid && !out_stall) begin
      r.var_index = out_variable_index;
      r.exponent = out_exponent;
      r.coefficient = out_coefficient;
      r.status = out_status;
      r.last = out_last;
      sb.check_result(r);
    end
  end

  task automatic send_word(input logic [7:0] sym, input logic end_marker);
    while (!calm && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_symbol <= sym;
    in_end_marker <= end_marker;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic send_end();
    send_word(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_digit();
    return 8'(CH_0 + $urandom_range(9));
  endfunction

  // Mostly well-formed terms with random content; some get a stray word or are cut short.
  function automatic void build_term();
    int kind;
    int nvar;
    int ndig;
    int pos;
    term_text.delete();
    if ($urandom_range(1)) term_text.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
    kind = $urandom_range(99);
    if (kind < 55) begin
      ndig = ($urandom_range(9) == 0) ? $urandom_range(10, 11) : $urandom_range(1, 3);
      repeat (ndig) term_text.push_back(rand_digit());
    end
    nvar = $urandom_range(4);
    if (nvar == 0 && kind >= 55) nvar = 1;
    repeat (nvar) begin
      term_text.push_back(8'(CH_A + ($urandom_range(1) ? $urandom_range(3)
                                                      : $urandom_range(NV - 1))));
      if ($urandom_range(1)) begin
        term_text.push_back(CH_CARET);
        ndig = ($urandom_range(7) == 0) ? 5 : $urandom_range(1, 2);
        repeat (ndig) term_text.push_back(rand_digit());
      end
    end
    if ($urandom_range(99) < 15) begin
      pos = $urandom_range(term_text.size());
      case ($urandom_range(2))
        0: term_text.insert(pos, 8'($urandom_range(255)));
        1: begin
          case ($urandom_range(3))
            0: term_text.insert(pos, CH_CARET);
            1: term_text.insert(pos, CH_PLUS);
            2: term_text.insert(pos, CH_MINUS);
            default: term_text.insert(pos, rand_digit());
          endcase
        end
        default: while (term_text.size() > pos) void'(term_text.pop_back());
      endcase
    end
  endfunction

  initial begin
    int nterm;
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_text("-12ab^3z");
    send_end();
    send_end();                 // empty term
    send_text("+0b");           // zero coefficient hides the exponents
    send_end();
    send_text("-^x");           // caret after a sign; the sign is never applied
    send_end();
    send_word(8'h00, 1'b0);
    send_end();
    send_text("a");
    send_word(8'hFF, 1'b0);
    send_end();
    send_text("a^99999");       // power wraps modulo 65536
    send_end();

    words_sent = 0;
    nterm = 0;
    while (words_sent < RANDOM_WORDS) begin
      if (nterm == 8) calm <= 1'b1;
      if (nterm == 26) calm <= 1'b0;
      if (nterm == 32) wait_drained();
      build_term();
      foreach (term_text[i]) send_word(term_text[i], 1'b0);
      send_end();
      nterm++;
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Checked %0d result words from %0d terms (%0d input words accepted).",
             sb.results_seen, sb.terms, sb.words_in);
    $display("Terms by status: %0d ok, %0d unknown symbol, %0d stopped early.",
             sb.term_status[0], sb.term_status[1], sb.term_status[2]);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d result words still expected.", sb.pending());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
